// ----- hdl/pfpu_pkg.sv -----
// ----------------------------------------------------------------------------
// pfpu_pkg
// Shared types, codes and pixel format helpers for the pixel format unit.
// ----------------------------------------------------------------------------
package pfpu_pkg;

  localparam int PALETTE_ENTRIES_DEF  = 256;
  localparam int RESERVED_ENTRIES_DEF = 16;
  localparam int COUNT_BITS_DEF       = 22;

  localparam logic [14:0] COARSE_DROP = 15'h0C63;

  localparam logic [1:0] DEPTH_PAL = 2'd0;
  localparam logic [1:0] DEPTH_555 = 2'd1;
  localparam logic [1:0] DEPTH_565 = 2'd2;
  localparam logic [1:0] DEPTH_24  = 2'd3;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_DEC   = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_APPLY = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  idx;
    logic [14:0] color;
    logic        set_color;
  } cell_cmd_t;

  typedef struct packed {
    logic        valid;
    logic        m_found;
    logic [7:0]  m_idx;
    logic        f_found;
    logic [7:0]  f_idx;
    logic [14:0] rd_color;
  } wave_t;

  function automatic logic [14:0] to555(input logic [23:0] c);
    return {c[23:19], c[15:11], c[7:3]};
  endfunction

  function automatic logic [15:0] to565(input logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [23:0] from555(input logic [14:0] w);
    return {w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
  endfunction

  function automatic logic [23:0] from565(input logic [15:0] w);
    return {w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
  endfunction

endpackage

// ----- hdl/pixel_format_palette_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_format_palette_unit
// Pixel word conversion with an allocating 8-bit palette held in a row of
// cells.
// ----------------------------------------------------------------------------
// Input words arrive on in_t*, results leave on out_t*, one result per word.
// cfg_valid/cfg_data write depth_mode; write it only while the unit is idle.
// Words are taken one at a time; in_tready is high only while idle.
// Palette writes and reads in 8-bit mode send a search wave through the row
// of PALETTE_ENTRIES cells, one cell per cycle; all other words skip the
// wave and go from S_EXEC to S_DONE. The next word can be accepted once the
// result register has loaded and the unit is back in idle.
// The result register decouples the sides: a new word is accepted while the
// previous result still waits for out_tready, and the unit holds in its
// final state until the result register is free.
// Reset clears every palette color and use count and sets depth_mode to 0;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_format_palette_unit
  import pfpu_pkg::*;
#(
  parameter int PALETTE_ENTRIES  = PALETTE_ENTRIES_DEF,
  parameter int RESERVED_ENTRIES = RESERVED_ENTRIES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0], color[25:2], old_pixel[49:26], entry_index[57:50], zero pad
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // value[23:0], dac_write[24], dac_index[32:25], dac_red[38:33],
  // dac_green[44:39], dac_blue[50:45], zero pad
  output logic [55:0] out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_LAUNCH = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t      st_r, st_nxt;
  logic [1:0]  depth_mode_r;
  logic [1:0]  mode_r;
  logic [23:0] color_r;
  logic [23:0] old_r;
  logic [7:0]  ei_r;

  logic [23:0] res_value_r;
  logic        res_dw_r;
  logic [7:0]  res_di_r;
  logic [5:0]  res_red_r, res_green_r, res_blue_r;
  logic [23:0] res_value_nxt;
  logic        res_dw_nxt;
  logic [7:0]  res_di_nxt;
  logic [5:0]  res_red_nxt, res_green_nxt, res_blue_nxt;

  logic        out_valid_r;
  logic [50:0] out_data_r;

  cell_cmd_t   cmd;
  logic [14:0] key;
  logic        pal_wr, pal_rd, load_ok, out_free;
  logic [7:0]  pick;
  logic        claim;
  wave_t       wave_w [0:PALETTE_ENTRIES];

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  assign key     = to555(color_r) & ~COARSE_DROP;
  assign pal_wr  = (mode_r == MODE_WRITE) && (depth_mode_r == DEPTH_PAL);
  assign pal_rd  = (mode_r == MODE_READ) && (depth_mode_r == DEPTH_PAL);
  assign load_ok = (mode_r == MODE_LOAD) && (32'(ei_r) < PALETTE_ENTRIES);

  assign claim = !wave_w[PALETTE_ENTRIES].m_found && wave_w[PALETTE_ENTRIES].f_found;
  always_comb begin
    if (wave_w[PALETTE_ENTRIES].m_found) pick = wave_w[PALETTE_ENTRIES].m_idx;
    else if (claim)                      pick = wave_w[PALETTE_ENTRIES].f_idx;
    else                                 pick = '0;
  end

  always_comb begin
    wave_w[0]       = '0;
    wave_w[0].valid = (st_r == S_LAUNCH);
  end

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    pfpu_cell #(
      .CELL_IDX         (g),
      .RESERVED_ENTRIES (RESERVED_ENTRIES),
      .COUNT_BITS       (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .key      (key),
      .rd_idx   (old_r[7:0]),
      .wave_in  (wave_w[g]),
      .wave_out (wave_w[g+1])
    );
  end

  always_comb begin
    st_nxt        = st_r;
    cmd           = '0;
    res_value_nxt = res_value_r;
    res_dw_nxt    = res_dw_r;
    res_di_nxt    = res_di_r;
    res_red_nxt   = res_red_r;
    res_green_nxt = res_green_r;
    res_blue_nxt  = res_blue_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) st_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_value_nxt = '0;
        res_dw_nxt    = 1'b0;
        res_di_nxt    = '0;
        res_red_nxt   = '0;
        res_green_nxt = '0;
        res_blue_nxt  = '0;
        if (pal_wr) begin
          cmd.op  = CMD_DEC;
          cmd.idx = old_r[7:0];
          st_nxt  = S_LAUNCH;
        end else if (pal_rd) begin
          st_nxt = S_LAUNCH;
        end else begin
          st_nxt = S_DONE;
          if (mode_r == MODE_WRITE) begin
            case (depth_mode_r)
              DEPTH_555: res_value_nxt = 24'(to555(color_r));
              DEPTH_565: res_value_nxt = 24'(to565(color_r));
              default:   res_value_nxt = color_r;
            endcase
          end else if (mode_r == MODE_READ) begin
            case (depth_mode_r)
              DEPTH_555: res_value_nxt = from555(old_r[14:0]);
              DEPTH_565: res_value_nxt = from565(old_r[15:0]);
              default:   res_value_nxt = old_r;
            endcase
          end else if (load_ok) begin
            cmd.op        = CMD_LOAD;
            cmd.idx       = ei_r;
            cmd.color     = to555(color_r);
            res_dw_nxt    = 1'b1;
            res_di_nxt    = ei_r;
            res_red_nxt   = color_r[23:18];
            res_green_nxt = color_r[15:10];
            res_blue_nxt  = color_r[7:2];
          end
        end
      end
      S_LAUNCH: begin
        st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (wave_w[PALETTE_ENTRIES].valid) begin
          st_nxt = S_DONE;
          if (pal_wr) begin
            cmd.op        = CMD_APPLY;
            cmd.idx       = pick;
            cmd.color     = key;
            cmd.set_color = claim;
            res_value_nxt = 24'(pick);
            if (claim) begin
              res_dw_nxt    = 1'b1;
              res_di_nxt    = pick;
              res_red_nxt   = {key[14:10], 1'b0};
              res_green_nxt = {key[9:5], 1'b0};
              res_blue_nxt  = {key[4:0], 1'b0};
            end
          end else begin
            res_value_nxt = from555(wave_w[PALETTE_ENTRIES].rd_color);
          end
        end
      end
      S_DONE: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      depth_mode_r <= DEPTH_PAL;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) depth_mode_r <= cfg_data;
      if (st_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)            out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r  <= in_tdata[1:0];
      color_r <= in_tdata[25:2];
      old_r   <= in_tdata[49:26];
      ei_r    <= in_tdata[57:50];
    end
    res_value_r <= res_value_nxt;
    res_dw_r    <= res_dw_nxt;
    res_di_r    <= res_di_nxt;
    res_red_r   <= res_red_nxt;
    res_green_r <= res_green_nxt;
    res_blue_r  <= res_blue_nxt;
    if (st_r == S_DONE && out_free) begin
      out_data_r <= {res_blue_r, res_green_r, res_red_r, res_di_r, res_dw_r, res_value_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_data_r};

endmodule

// ----- hdl/pfpu_cell.sv -----
// ----------------------------------------------------------------------------
// pfpu_cell
// One palette entry: color, use count and one stage of the search wave.
// ----------------------------------------------------------------------------
module pfpu_cell
  import pfpu_pkg::*;
#(
  parameter int CELL_IDX         = 0,
  parameter int RESERVED_ENTRIES = RESERVED_ENTRIES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  logic [14:0] key,
  input  logic [7:0]  rd_idx,
  input  wave_t       wave_in,
  output wave_t       wave_out
);

  localparam logic [7:0]            MY_IDX    = CELL_IDX[7:0];
  localparam logic                  FREE_OK   = (CELL_IDX >= RESERVED_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [14:0]           color_r;
  logic [COUNT_BITS-1:0] count_r;
  wave_t                 wave_r;
  wave_t                 wave_nxt;
  logic                  hit;

  assign hit = (cmd.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
      count_r <= '0;
    end else begin
      case (cmd.op)
        CMD_DEC: begin
          if (hit && count_r != '0) count_r <= count_r - 1'b1;
        end
        CMD_LOAD: begin
          if (hit) begin
            color_r <= cmd.color;
            count_r <= '0;
          end
        end
        CMD_APPLY: begin
          if (hit) begin
            if (cmd.set_color) color_r <= cmd.color;
            if (count_r != COUNT_MAX) count_r <= count_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    wave_nxt = wave_in;
    if (wave_in.valid) begin
      if (!wave_in.m_found && color_r == key) begin
        wave_nxt.m_found = 1'b1;
        wave_nxt.m_idx   = MY_IDX;
      end
      if (FREE_OK && !wave_in.f_found && count_r == '0) begin
        wave_nxt.f_found = 1'b1;
        wave_nxt.f_idx   = MY_IDX;
      end
      if (rd_idx == MY_IDX) wave_nxt.rd_color = color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule
